// ===== hdl/rate_limit_delay_controller_core_assert.svh =====
// Assertion macros used by the rate limit delay controller checker.
`ifndef RATE_LIMIT_DELAY_CONTROLLER_CORE_ASSERT_SVH
`define RATE_LIMIT_DELAY_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLDC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RLDC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rldc_pkg.sv =====
// Shared widths, constants and register codes of the rate limit delay controller.
`timescale 1ns / 1ps
`default_nettype none
package rldc_pkg;

	localparam int SLOT_W      = 6;
	localparam int SLOT_CNT    = 1 << SLOT_W;
	localparam int RATE_W      = 48;
	localparam int DLY_W       = 24;
	localparam int KP_W        = 14;
	localparam int PROD_W      = DLY_W + KP_W;
	localparam int RATIO_INT_W = 16;
	localparam int CFG_IDX_W   = 2;

	// Controller gains, unsigned Q0.16
	localparam logic [KP_W-1:0] KP_UP   = 14'd9830;
	localparam logic [KP_W-1:0] KP_DOWN = 14'd3277;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KICKSTART = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHUTOFF   = 2'd3;

	// Register reset values
	localparam logic [DLY_W-1:0] MAX_DELAY_RST = 24'd1000000;
	localparam logic [DLY_W-1:0] MAX_STEP_RST  = 24'd50000;
	localparam logic [DLY_W-1:0] KICKSTART_RST = 24'd100;
	localparam logic [DLY_W-1:0] SHUTOFF_RST   = 24'd10;

endpackage
`default_nettype wire

// ===== hdl/rldc_div.sv =====
// Bit-serial restoring divider producing the saturated rate ratio.
`timescale 1ns / 1ps
`default_nettype none
module rldc_div #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            load,
	input  wire logic [rldc_pkg::RATE_W-1:0]     num,
	input  wire logic [rldc_pkg::RATE_W-1:0]     den,
	output logic [rldc_pkg::RATIO_INT_W+FRAC_BITS-1:0] quo,
	output logic                                 done
);

	localparam int RW = rldc_pkg::RATE_W;
	localparam int IW = rldc_pkg::RATIO_INT_W;
	localparam int QW = IW + FRAC_BITS;
	localparam int CW = $clog2(QW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] den_q;
	logic [QW-1:0] sh_q;
	logic          sat_q;
	logic [RW:0]   trial;
	logic          ge;
	logic [RW:0]   diff;

	// Shift in the next dividend bit, subtract the divisor when it fits
	assign trial = {rem_q, sh_q[QW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				cnt_q <= CW'(QW);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= {{IW{1'b0}}, num[RW-1:IW]};
			sh_q  <= {num[IW-1:0], {FRAC_BITS{1'b0}}};
			den_q <= den;
			sat_q <= {{IW{1'b0}}, num[RW-1:IW]} >= den;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[RW-1:0] : trial[RW-1:0];
			sh_q  <= {sh_q[QW-2:0], ge};
		end
	end

	assign quo  = sat_q ? {QW{1'b1}} : sh_q;
	assign done = done_q;

endmodule
`default_nettype wire

// ===== hdl/rldc_mul.sv =====
// Bit-serial shift-add multiplier keeping the high part and a sticky bit.
`timescale 1ns / 1ps
`default_nettype none
module rldc_mul #(
	parameter int NB = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         load,
	input  wire logic [rldc_pkg::PROD_W-1:0]  mcand,
	input  wire logic [NB-1:0]                mplier,
	output logic [rldc_pkg::PROD_W-1:0]       prod,
	output logic                              sticky,
	output logic                              done
);

	localparam int PW = rldc_pkg::PROD_W;
	localparam int CW = $clog2(NB + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [PW-1:0] mc_q;
	logic [NB-1:0] mp_q;
	logic [PW-1:0] acc_q;
	logic          sticky_q;
	logic [PW:0]   sum;

	// Add the multiplicand for a set multiplier bit, then drop one bit off the bottom
	assign sum = {1'b0, acc_q} + (mp_q[0] ? {1'b0, mc_q} : {(PW+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				cnt_q <= CW'(NB);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mc_q     <= mcand;
			mp_q     <= mplier;
			acc_q    <= '0;
			sticky_q <= 1'b0;
		end else if (cnt_q != '0) begin
			acc_q    <= sum[PW:1];
			sticky_q <= sticky_q | sum[0];
			mp_q     <= mp_q >> 1;
		end
	end

	assign prod   = acc_q;
	assign sticky = sticky_q;
	assign done   = done_q;

endmodule
`default_nettype wire

// ===== hdl/rate_limit_delay_controller_core.sv =====
// Top level of the rate limit delay controller: slot store, sequencer and delay update.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Input: drive slot, rate_cap, rate_meas and policy_active and raise start;
//   the beat is taken at a rising edge with start high and busy low.
//   Output: done is high for exactly one cycle; out_slot, delay_value and dispatch
//   carry that beat's result and hold until the next beat is checked. The receiver
//   cannot stall, so no result is ever held back.
//   Config: cfg_valid/cfg_ready write cfg_data into register cfg_index
//   (0 max delay, 1 max step, 2 kickstart, 3 shutoff); cfg_ready is always high.
//   Write registers only while the block is idle.
// Sequence
//   Out-of-range slot, inactive policy or zero limit: the check state reports at
//   once and done rises as the block returns to idle. An update runs from the check
//   through the bit-serial ratio divider and the bit-serial multiplier, one bit per
//   cycle each, and a final write-back state before done rises.
//   A new beat is taken in the same cycle that done shows.
// Reset
//   arst_n clears control and loads the register defaults, then a clearing pass
//   zeroes the min(NUM_SLOTS,64) slot store entries, one entry per cycle, with busy
//   high throughout. Configuration writes are taken during the pass.
module rate_limit_delay_controller_core #(
	parameter int NUM_SLOTS       = 64,
	parameter int RATIO_FRAC_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [rldc_pkg::SLOT_W-1:0]         slot,
	input  wire logic [rldc_pkg::RATE_W-1:0]         rate_cap,
	input  wire logic [rldc_pkg::RATE_W-1:0]         rate_meas,
	input  wire logic                                policy_active,
	output logic                                     done,
	output logic [rldc_pkg::SLOT_W-1:0]              out_slot,
	output logic [rldc_pkg::DLY_W-1:0]               delay_value,
	output logic                                     dispatch,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [rldc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rldc_pkg::DLY_W-1:0]          cfg_data
);

	localparam int DW    = rldc_pkg::DLY_W;
	localparam int PW    = rldc_pkg::PROD_W;
	localparam int SW    = rldc_pkg::SLOT_W;
	localparam int RTW   = rldc_pkg::RATE_W;
	localparam int QW    = rldc_pkg::RATIO_INT_W + RATIO_FRAC_BITS;
	localparam int DEPTH = (NUM_SLOTS < rldc_pkg::SLOT_CNT) ? NUM_SLOTS : rldc_pkg::SLOT_CNT;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [QW-1:0] RATIO_ONE = QW'(1) << RATIO_FRAC_BITS;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_MUL   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	// Control
	logic [2:0]    state_q;
	logic [AW-1:0] clr_cnt_q;
	logic          done_q;
	logic [DW-1:0] max_delay_q;
	logic [DW-1:0] max_step_q;
	logic [DW-1:0] kick_us_q;
	logic [DW-1:0] shutoff_q;

	// Captured beat and working values
	logic [SW-1:0]  slot_q;
	logic [RTW-1:0] lim_q;
	logic [RTW-1:0] cur_q;
	logic           act_q;
	logic           inr_q;
	logic [DW-1:0]  dly_q;
	logic           up_q;
	logic           lt_q;
	logic           kick_q;
	logic [DW:0]    new_q;
	logic [SW-1:0]  out_slot_q;
	logic [DW-1:0]  out_dly_q;
	logic           out_disp_q;

	// Slot store
	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [DW-1:0] mem_wdata;

	// Serial units
	logic          div_load;
	logic [QW-1:0] ratio;
	logic          div_done;
	logic          mul_load;
	logic [PW-1:0] mcand;
	logic [QW-1:0] dev;
	logic [PW-1:0] prod;
	logic          mul_sticky;
	logic          mul_done;

	// Datapath
	logic           accept;
	logic           upd;
	logic           slot_inr;
	logic           ratio_ge;
	logic           ratio_gt;
	logic [rldc_pkg::KP_W-1:0] kp;
	logic [PW:0]    q_inc;
	logic [DW-1:0]  step;
	logic [DW:0]    adj_up;
	logic [DW:0]    adj_dn;
	logic [DW:0]    adj;
	logic [DW-1:0]  bnd;
	logic [DW-1:0]  fin_dly;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign slot_inr  = (32'(slot) < 32'(NUM_SLOTS));
	assign upd       = inr_q && act_q && (lim_q != '0);

	// Ratio flags and the scaled delay fed to the multiplier
	assign ratio_ge = (ratio >= RATIO_ONE);
	assign ratio_gt = (ratio > RATIO_ONE);
	assign dev      = ratio_ge ? (ratio - RATIO_ONE) : (RATIO_ONE - ratio);
	assign kp       = ratio_gt ? rldc_pkg::KP_UP : rldc_pkg::KP_DOWN;
	assign mcand    = PW'(dly_q) * PW'(kp);

	assign div_load = (state_q == ST_CHECK) && upd;
	assign mul_load = (state_q == ST_DIV) && div_done;

	// Change of delay: floor going up, ceiling going down, limited to max step; kickstart from zero
	assign q_inc  = {1'b0, prod} + {{PW{1'b0}}, (!up_q && mul_sticky)};
	assign step   = (q_inc > (PW+1)'(max_step_q)) ? max_step_q : q_inc[DW-1:0];
	assign adj_up = {1'b0, dly_q} + {1'b0, step};
	assign adj_dn = (dly_q >= step) ? {1'b0, dly_q - step} : '0;
	assign adj    = kick_q ? {1'b0, kick_us_q} : (up_q ? adj_up : adj_dn);

	// Bound, then switch off small delays under the limit
	assign bnd     = (new_q > {1'b0, max_delay_q}) ? max_delay_q : new_q[DW-1:0];
	assign fin_dly = (lt_q && (bnd < shutoff_q)) ? '0 : bnd;

	assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_FIN);
	assign mem_addr  = (state_q == ST_CLEAR) ? clr_cnt_q : slot_q[AW-1:0];
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : fin_dly;

	rldc_div #(
		.FRAC_BITS(RATIO_FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (div_load),
		.num   (cur_q),
		.den   (lim_q),
		.quo   (ratio),
		.done  (div_done)
	);

	rldc_mul #(
		.NB(QW)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (mul_load),
		.mcand (mcand),
		.mplier(dev),
		.prod  (prod),
		.sticky(mul_sticky),
		.done  (mul_done)
	);

	// Sequencer and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			done_q      <= 1'b0;
			max_delay_q <= rldc_pkg::MAX_DELAY_RST;
			max_step_q  <= rldc_pkg::MAX_STEP_RST;
			kick_us_q   <= rldc_pkg::KICKSTART_RST;
			shutoff_q   <= rldc_pkg::SHUTOFF_RST;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rldc_pkg::REG_MAX_DELAY: max_delay_q <= cfg_data;
					rldc_pkg::REG_MAX_STEP:  max_step_q  <= cfg_data;
					rldc_pkg::REG_KICKSTART: kick_us_q   <= cfg_data;
					rldc_pkg::REG_SHUTOFF:   shutoff_q   <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					// No update: report right away
					if (upd) begin
						state_q <= ST_DIV;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Beat capture and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q <= slot;
			lim_q  <= rate_cap;
			cur_q  <= rate_meas;
			act_q  <= policy_active;
			inr_q  <= slot_inr;
		end
		if (state_q == ST_CHECK) begin
			dly_q      <= rd_q;
			out_slot_q <= slot_q;
			out_dly_q  <= inr_q ? rd_q : '0;
			out_disp_q <= 1'b0;
		end
		if (mul_load) begin
			up_q   <= ratio_ge;
			lt_q   <= !ratio_ge;
			kick_q <= (dly_q == '0) && ratio_gt;
		end
		if ((state_q == ST_MUL) && mul_done) begin
			new_q <= adj;
		end
		if (state_q == ST_FIN) begin
			out_dly_q  <= fin_dly;
			out_disp_q <= (fin_dly != '0);
		end
	end

	// Slot store: one write port, registered read at the incoming slot
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wdata;
		end
		rd_q <= mem_q[slot[AW-1:0]];
	end

	assign done        = done_q;
	assign out_slot    = out_slot_q;
	assign delay_value = out_dly_q;
	assign dispatch    = out_disp_q;

endmodule
`default_nettype wire

// ===== hdl/rldc_checker.sv =====
// Port-level checker for the rate limit delay controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "rate_limit_delay_controller_core_assert.svh"
module rldc_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           start,
	input wire logic                           busy,
	input wire logic                           done,
	input wire logic [rldc_pkg::DLY_W-1:0]     delay_value,
	input wire logic                           dispatch
);

	// An accepted beat keeps the block busy on the next cycle
	`RLDC_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accept did not raise busy")

	// A result shows only when the block has just finished its work
	`RLDC_ASSERT_IMP(a_done_after_busy, clk, arst_n, done, $past(busy) && !busy, "done without work")

	// The result strobe lasts one cycle
	`RLDC_ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done, "done held over two cycles")

	// Dispatch goes out only with a nonzero delay
	`RLDC_ASSERT_IMP(a_dispatch_nonzero, clk, arst_n, done && dispatch, delay_value != '0, "dispatch with zero delay")

endmodule

bind rate_limit_delay_controller_core rldc_checker u_rldc_checker (.*);
`default_nettype wire

// ===== tb/rate_limit_delay_controller_core_test.sv =====
// Testbench for the rate limit delay controller core: directed and random beats, self-checked.
`timescale 1ns / 1ps
module rate_limit_delay_controller_core_test;

	// Cap on the whole run in clock cycles. The slowest correct run is about 2000 beats
	// plus sender gaps, and stays under this cap.
	localparam int CYCLE_CAP = 1000000;

	// Unity ratio in Q16.16
	localparam logic [31:0] RATIO_UNITY = 32'h0001_0000;
	localparam logic [31:0] RATIO_FULL  = 32'hFFFF_FFFF;

	// Expected content of one result beat
	typedef struct packed {
		logic [rldc_pkg::SLOT_W-1:0] slot;
		logic [rldc_pkg::DLY_W-1:0]  delay;
		logic                        dispatch;
	} delay_beat_t;

	// Delay predictor and expected result queue. note_beat advances the per-slot
	// delays for every accepted input beat; check_result compares each result beat
	// with the oldest expectation.
	class delay_scoreboard_t;
		logic [rldc_pkg::DLY_W-1:0] max_delay;
		logic [rldc_pkg::DLY_W-1:0] max_step;
		logic [rldc_pkg::DLY_W-1:0] kickstart;
		logic [rldc_pkg::DLY_W-1:0] shutoff;
		logic [rldc_pkg::DLY_W-1:0] delay_mem [rldc_pkg::SLOT_CNT];
		delay_beat_t                pending_q [$];
		int                         errors;
		int                         beats;
		int                         checked;
		int                         dispatched;
		int                         changed;

		function new();
			max_delay = rldc_pkg::MAX_DELAY_RST;
			max_step  = rldc_pkg::MAX_STEP_RST;
			kickstart = rldc_pkg::KICKSTART_RST;
			shutoff   = rldc_pkg::SHUTOFF_RST;
			foreach (delay_mem[i]) delay_mem[i] = '0;
			errors     = 0;
			beats      = 0;
			checked    = 0;
			dispatched = 0;
			changed    = 0;
		endfunction

		function void set_reg(logic [rldc_pkg::CFG_IDX_W-1:0] idx,
				logic [rldc_pkg::DLY_W-1:0] val);
			case (idx)
				rldc_pkg::REG_MAX_DELAY: max_delay = val;
				rldc_pkg::REG_MAX_STEP:  max_step  = val;
				rldc_pkg::REG_KICKSTART: kickstart = val;
				rldc_pkg::REG_SHUTOFF:   shutoff   = val;
				default: ;
			endcase
		endfunction

		function int outstanding();
			return pending_q.size();
		endfunction

		function void note_beat(logic [rldc_pkg::SLOT_W-1:0] s,
				logic [rldc_pkg::RATE_W-1:0] lim, logic [rldc_pkg::RATE_W-1:0] cur,
				logic act);
			delay_beat_t                want;
			logic [rldc_pkg::DLY_W-1:0] held;
			logic [79:0]                quo;
			logic [31:0]                ratio;
			logic [31:0]                dev;
			logic [13:0]                gain;
			logic                       up;
			logic [79:0]                prod;
			logic [79:0]                step;
			logic [79:0]                nxt;
			held = delay_mem[s];
			want.slot = s;
			want.delay = held;
			want.dispatch = 1'b0;
			beats++;
			if (act && lim != '0) begin
				// Q16.16 ratio, truncated; an integer part past 16 bits saturates
				quo = {32'b0, cur};
				quo = (quo << 16) / lim;
				ratio = (quo > 80'hFFFF_FFFF) ? RATIO_FULL : quo[31:0];
				if (held == '0 && ratio > RATIO_UNITY) begin
					nxt = 80'(kickstart);
				end else begin
					up = ratio >= RATIO_UNITY;
					dev = up ? ratio - RATIO_UNITY : RATIO_UNITY - ratio;
					gain = (ratio > RATIO_UNITY) ? rldc_pkg::KP_UP : rldc_pkg::KP_DOWN;
					// delay*(ratio-1)*kp carries 32 fraction bits; floor it, which means
					// rounding the magnitude up when the change is downward
					prod = {56'b0, held};
					prod = prod * dev * gain;
					step = prod >> 32;
					if (!up && prod[31:0] != '0) step = step + 1;
					if (step > max_step) step = 80'(max_step);
					if (up) nxt = held + step;
					else nxt = (held >= step) ? held - step : '0;
				end
				if (nxt > max_delay) nxt = 80'(max_delay);
				if (nxt < shutoff && ratio < RATIO_UNITY) nxt = '0;
				if (nxt[rldc_pkg::DLY_W-1:0] != held) changed++;
				delay_mem[s] = nxt[rldc_pkg::DLY_W-1:0];
				want.delay = nxt[rldc_pkg::DLY_W-1:0];
				want.dispatch = (nxt != '0);
			end
			if (want.dispatch) dispatched++;
			pending_q.push_back(want);
		endfunction

		function void check_result(logic [rldc_pkg::SLOT_W-1:0] s,
				logic [rldc_pkg::DLY_W-1:0] d, logic disp);
			delay_beat_t want;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: result beat with none outstanding: slot %0d delay %0d dispatch %0b",
					$time, s, d, disp);
				return;
			end
			want = pending_q.pop_front();
			checked++;
			if (s !== want.slot) begin
				errors++;
				$display("%0t: out_slot expected %0d actual %0d", $time, want.slot, s);
			end
			if (d !== want.delay) begin
				errors++;
				$display("%0t: delay_value (slot %0d) expected %0d actual %0d",
					$time, want.slot, want.delay, d);
			end
			if (disp !== want.dispatch) begin
				errors++;
				$display("%0t: dispatch (slot %0d) expected %0b actual %0b",
					$time, want.slot, want.dispatch, disp);
			end
		endfunction
	endclass

	// Clock, reset and the block's inputs, all known from time zero
	logic                           clk           = 1'b0;
	logic                           arst_n        = 1'b0;
	logic                           start         = 1'b0;
	logic [rldc_pkg::SLOT_W-1:0]    slot          = '0;
	logic [rldc_pkg::RATE_W-1:0]    rate_cap      = '0;
	logic [rldc_pkg::RATE_W-1:0]    rate_meas     = '0;
	logic                           policy_active = 1'b0;
	logic                           cfg_valid     = 1'b0;
	logic [rldc_pkg::CFG_IDX_W-1:0] cfg_index     = rldc_pkg::REG_MAX_DELAY;
	logic [rldc_pkg::DLY_W-1:0]     cfg_data      = '0;

	logic                           busy;
	logic                           done;
	logic [rldc_pkg::SLOT_W-1:0]    out_slot;
	logic [rldc_pkg::DLY_W-1:0]     delay_value;
	logic                           dispatch;
	logic                           cfg_ready;

	int                             cycle_count = 0;
	delay_scoreboard_t              sb;

	rate_limit_delay_controller_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.slot          (slot),
		.rate_cap      (rate_cap),
		.rate_meas     (rate_meas),
		.policy_active (policy_active),
		.done          (done),
		.out_slot      (out_slot),
		.delay_value   (delay_value),
		.dispatch      (dispatch),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	// Hard stop: anything still outstanding at this point is a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_CAP) begin
			$display("rate_limit_delay_controller_core_test: errors");
			$finish;
		end
	end

	// Take every result beat at the edge that ends its strobe cycle. Values read
	// here are the ones from before the edge, so the order of processes in the
	// time step does not matter.
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(out_slot, delay_value, dispatch);
	end

	// Present one input beat and hold it until the block takes it. Start stays high
	// on return so that a following beat can go out back to back; callers that
	// pause lower it themselves.
	task automatic send_beat(input logic [rldc_pkg::SLOT_W-1:0] s,
			input logic [rldc_pkg::RATE_W-1:0] lim,
			input logic [rldc_pkg::RATE_W-1:0] cur, input logic act);
		slot          <= s;
		rate_cap      <= lim;
		rate_meas     <= cur;
		policy_active <= act;
		start         <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_beat(s, lim, cur, act);
	endtask

	// Write one register. Valid stays high on return so that writes can go out
	// back to back; the caller drops it after the last one.
	task automatic load_reg(input logic [rldc_pkg::CFG_IDX_W-1:0] idx,
			input logic [rldc_pkg::DLY_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val);
	endtask

	// Stop sending, wait for every outstanding result, then let the block settle
	task automatic drain(input int settle);
		start <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Random beats. Most traffic hits a handful of slots with rates near their
	// limits so that delays climb, settle and decay through many updates; the rest
	// covers full-range fields, zero limits, saturated ratios and inactive policies.
	task automatic run_random(input int count, input bit quiet);
		logic [63:0]                 wide;
		logic [rldc_pkg::RATE_W-1:0] lim;
		logic [rldc_pkg::RATE_W-1:0] cur;
		logic [rldc_pkg::SLOT_W-1:0] s;
		logic                        act;
		int                          k;
		repeat (count) begin
			if (!quiet && $urandom_range(0, 99) < 35) begin
				start <= 1'b0;
				// mostly short gaps, now and then a longer one that can outlast a whole update
				repeat (($urandom_range(0, 9) == 0) ? $urandom_range(7, 90)
						: $urandom_range(1, 6)) @(posedge clk);
			end
			s = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 7))
				: 6'($urandom_range(0, 63));
			act = ($urandom_range(0, 15) != 0);
			k = $urandom_range(0, 19);
			wide = {$urandom, $urandom};
			if (k == 0) begin
				lim = '0;
			end else if (k < 3) begin
				lim = wide[47:0];
			end else if (k < 5) begin
				lim = 48'($urandom_range(1, 10));
			end else begin
				lim = wide[47:0] >> $urandom_range(0, 47);
				if (lim == '0) lim = 1;
			end
			k = $urandom_range(0, 19);
			wide = {$urandom, $urandom};
			if (k == 0) begin
				cur = wide[47:0];
			end else if (k == 1) begin
				cur = '0;
			end else if (k == 2) begin
				cur = '1;
			end else begin
				// hug the limit, or scale it by 0.5 to 2.0
				if (k < 6) wide = {16'b0, lim} + $urandom_range(0, 2) - 1;
				else wide = ({16'b0, lim} * $urandom_range(64, 256)) >> 7;
				cur = (wide > 64'hFFFF_FFFF_FFFF) ? '1 : wide[47:0];
			end
			send_beat(s, lim, cur, act);
		end
	endtask

	initial begin : stimulus
		logic [rldc_pkg::DLY_W-1:0] lim_max;
		logic [rldc_pkg::DLY_W-1:0] step_max;
		logic [rldc_pkg::DLY_W-1:0] kick;
		logic [rldc_pkg::DLY_W-1:0] floor_us;
		int                         ph;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats at the reset settings; the block's clearing pass holds
		// busy until the store is zero, so the first beat simply waits for it
		send_beat(6'd0, 48'd0, 48'd5000, 1'b1);                // zero limit: no update
		send_beat(6'd1, 48'd100, 48'd200, 1'b0);               // inactive policy
		send_beat(6'd0, 48'd1000, 48'd1000, 1'b1);             // ratio one from zero
		send_beat(6'd0, 48'd1000, 48'd2000, 1'b1);             // kickstart
		send_beat(6'd0, 48'd1000, 48'd2000, 1'b1);             // scale up by the high gain
		send_beat(6'd0, 48'd1, '1, 1'b1);                      // saturated ratio, step limit
		send_beat(6'd0, 48'd1000, 48'd0, 1'b1);                // ratio zero, scale down
		send_beat(6'd0, '1, '1, 1'b0);                         // inactive: report stored delay
		send_beat(6'd63, '1, '1, 1'b1);                        // ratio one at full fields
		send_beat(6'd63, '1, 48'd0, 1'b1);                     // down from zero stays zero
		send_beat(6'd63, 48'd1, '1, 1'b1);                     // kickstart on saturated ratio
		send_beat(6'd63, '1, 48'h7FFF_FFFF_FFFF, 1'b1);        // ratio just under one half
		send_beat(6'd62, 48'h8000_0000_0000, 48'h8000_0000_0001, 1'b1); // truncates to one

		// Shutoff: a small kickstart decays below the floor and drops to zero
		drain(4);
		load_reg(rldc_pkg::REG_KICKSTART, 24'd5);
		cfg_valid <= 1'b0;
		send_beat(6'd3, 48'd1, 48'd2, 1'b1);
		send_beat(6'd3, 48'd10, 48'd9, 1'b1);

		// Kickstart above the ceiling is held to the ceiling, and so is growth
		drain(4);
		load_reg(rldc_pkg::REG_MAX_DELAY, 24'd60);
		load_reg(rldc_pkg::REG_KICKSTART, 24'd200);
		cfg_valid <= 1'b0;
		send_beat(6'd4, 48'd1, 48'd3, 1'b1);
		send_beat(6'd4, 48'd1, 48'd3, 1'b1);

		// Random phases, each under its own register setting. Every phase starts
		// from an idle block: the sender holds off until all results are back.
		for (ph = 0; ph < 8; ph++) begin
			drain(4);
			case (ph)
				0: begin
					lim_max = rldc_pkg::MAX_DELAY_RST; step_max = rldc_pkg::MAX_STEP_RST;
					kick = rldc_pkg::KICKSTART_RST; floor_us = rldc_pkg::SHUTOFF_RST;
				end
				1: begin
					lim_max = '1; step_max = '1; kick = '1; floor_us = '1;
				end
				2: begin
					lim_max = '0; step_max = '0; kick = '0; floor_us = '0;
				end
				3: begin
					lim_max = '1; step_max = '0; kick = 24'd1; floor_us = '0;
				end
				4: begin
					lim_max = 24'($urandom); step_max = 24'($urandom);
					kick = 24'($urandom); floor_us = 24'($urandom);
				end
				7: begin
					lim_max = '1; step_max = 24'h80_0000; kick = 24'd1; floor_us = 24'd1000;
				end
				default: begin
					lim_max = 24'($urandom_range(1000, 2000000));
					step_max = 24'($urandom_range(1, 20000));
					kick = 24'($urandom_range(1, 500));
					floor_us = 24'($urandom_range(0, 100));
				end
			endcase
			load_reg(rldc_pkg::REG_MAX_DELAY, lim_max);
			load_reg(rldc_pkg::REG_MAX_STEP, step_max);
			load_reg(rldc_pkg::REG_KICKSTART, kick);
			load_reg(rldc_pkg::REG_SHUTOFF, floor_us);
			cfg_valid <= 1'b0;
			// one phase runs with the sender never idle
			run_random(240, ph == 5);
		end

		// Wait out the last results plus one full update for anything stray
		drain(80);
		$display("covered %0d beats under 11 register settings, directed corner cases first",
			sb.beats);
		$display("%0d results checked, %0d carried dispatch, %0d changed a stored delay",
			sb.checked, sb.dispatched, sb.changed);
		if (sb.errors == 0) begin
			$display("rate_limit_delay_controller_core_test: clean");
		end else begin
			$display("rate_limit_delay_controller_core_test: errors");
		end
		$finish;
	end

endmodule
